// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/tpag_pkg.sv -----
package tpag_pkg;

    localparam int NUM_AXES   = 4;
    localparam int AX_W       = 2;
    localparam int SIZE_W     = 11;
    localparam int IDX_W      = 40;
    localparam int RANK_W     = 3;
    localparam int ORDER_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [SIZE_W-1:0] MAX_EXTENT = 11'd1024;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RANK       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORDER = 3'd5;

    localparam logic [RANK_W-1:0]  RANK_RST  = 3'd2;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 11'd1;
    localparam logic [ORDER_W-1:0] ORDER_RST = 8'd228;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture an accepted item and advance the odometer
        logic step;   // one Horner step of the destination index
        logic emit;   // move the finished item into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_step;
        logic out_free;
    } t_sts;

    // Clamp a configured extent into 1..1024
    function automatic logic [SIZE_W-1:0] f_extent(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] e;
        e = size;
        if (size == '0) begin
            e = SIZE_W'(1);
        end else if (size > MAX_EXTENT) begin
            e = MAX_EXTENT;
        end
        return e;
    endfunction

endpackage

// ----- rtl/tpag_in_if.sv -----
interface tpag_in_if #(
    parameter int ELEM_BITS = 32
) ();
    logic                 valid;
    logic                 ready;
    logic [ELEM_BITS-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

// ----- rtl/tpag_out_if.sv -----
interface tpag_out_if #(
    parameter int ELEM_BITS = 32
) ();
    logic                 valid;
    logic                 ready;
    logic [39:0]          dest_index;
    logic [ELEM_BITS-1:0] value_out;
    logic                 last_element;

    modport source (output valid, output dest_index, output value_out, output last_element,
                    input ready);
    modport sink   (input valid, input dest_index, input value_out, input last_element,
                    output ready);
endinterface

// ----- rtl/tpag_ctrl.sv -----
module tpag_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tpag_pkg::t_sts i_sts,
    output tpag_pkg::t_cmd o_cmd
);
    import tpag_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_step) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register can take the item
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/tpag_dp.sv -----
module tpag_dp #(
    parameter int MAX_RANK  = 4,
    parameter int ELEM_BITS = 32,
    parameter int AXIS_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tpag_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tpag_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [ELEM_BITS-1:0]              i_element_value,
    input  tpag_pkg::t_cmd                    i_cmd,
    output tpag_pkg::t_sts                    o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [tpag_pkg::IDX_W-1:0]        o_dest_index,
    output logic [ELEM_BITS-1:0]              o_value_out,
    output logic                              o_last_element
);
    `include "assert_macros.svh"
    import tpag_pkg::*;

    localparam int RANK_LIM = (MAX_RANK < NUM_AXES) ? MAX_RANK : NUM_AXES;
    localparam int CMP_W    = (AXIS_BITS + 1 > SIZE_W) ? AXIS_BITS + 1 : SIZE_W;
    localparam int PROD_W   = IDX_W + SIZE_W;

    // configuration
    logic [RANK_W-1:0]  r_rank;
    logic [SIZE_W-1:0]  r_size [NUM_AXES];
    logic [ORDER_W-1:0] r_order;

    // odometer and per-item work
    logic [AXIS_BITS-1:0] r_pos  [NUM_AXES];
    logic [AXIS_BITS-1:0] n_pos  [NUM_AXES];
    logic [AXIS_BITS-1:0] r_snap [NUM_AXES];
    logic [ELEM_BITS-1:0] r_val;
    logic                 r_last;
    logic                 n_last;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     n_idx;
    logic [AX_W-1:0]      r_d;

    // output register
    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_out_idx;
    logic [ELEM_BITS-1:0] r_out_val;
    logic                 r_out_last;

    logic [RANK_W-1:0]    eff_rank;
    logic [AX_W-1:0]      order_f [NUM_AXES];
    logic [AX_W-1:0]      src;
    logic                 src_used;
    logic [SIZE_W-1:0]    src_ext;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W-1:0]    acc;

    always_comb begin
        eff_rank = r_rank;
        if (r_rank == '0) begin
            eff_rank = RANK_W'(1);
        end else if (r_rank > RANK_W'(RANK_LIM)) begin
            eff_rank = RANK_W'(RANK_LIM);
        end
    end

    always_comb begin
        for (int d = 0; d < NUM_AXES; d++) begin
            order_f[d] = r_order[AX_W*d +: AX_W];
        end
    end

    // Horner step over destination axes; an unused source axis leaves the index unchanged
    assign src      = order_f[r_d];
    assign src_used = ({1'b0, src} < eff_rank);
    assign src_ext  = f_extent(r_size[src]);
    assign prod     = PROD_W'(r_idx) * PROD_W'(src_ext);
    assign acc      = prod + PROD_W'(r_snap[src]);
    assign n_idx    = src_used ? acc[IDX_W-1:0] : r_idx;

    // Odometer advance, innermost used axis first; unused axes clear
    always_comb begin
        logic             carry;
        logic [CMP_W-1:0] p;
        logic [CMP_W-1:0] ext;
        carry = 1'b1;
        p     = '0;
        ext   = '0;
        for (int k = NUM_AXES - 1; k >= 0; k--) begin
            n_pos[k] = r_pos[k];
            if (RANK_W'(k) >= eff_rank) begin
                n_pos[k] = '0;
            end else if (carry) begin
                p   = CMP_W'(r_pos[k]) + CMP_W'(1);
                ext = CMP_W'(f_extent(r_size[k]));
                if (p >= ext) begin
                    n_pos[k] = '0;
                end else begin
                    n_pos[k] = p[AXIS_BITS-1:0];
                    carry    = 1'b0;
                end
            end
        end
        n_last = carry;
    end

    assign o_sts.last_step = ({1'b0, r_d} == (eff_rank - RANK_W'(1)));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank  <= RANK_RST;
            r_order <= ORDER_RST;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_size[a] <= SIZE_RST;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RANK:       r_rank    <= i_cfg_data[RANK_W-1:0];
                REG_SIZE_AXIS0: r_size[0] <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_AXIS1: r_size[1] <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_AXIS2: r_size[2] <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_AXIS3: r_size[3] <= i_cfg_data[SIZE_W-1:0];
                REG_AXIS_ORDER: r_order   <= i_cfg_data[ORDER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_pos[a] <= '0;
            end
        end else if (i_cmd.load) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val  <= i_element_value;
            r_last <= n_last;
            r_idx  <= '0;
            r_d    <= '0;
            // snapshot coordinates before the advance, unused axes as zero
            for (int a = 0; a < NUM_AXES; a++) begin
                r_snap[a] <= (RANK_W'(a) < eff_rank) ? r_pos[a] : '0;
            end
        end else if (i_cmd.step) begin
            r_idx <= n_idx;
            r_d   <= r_d + AX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_idx  <= r_idx;
            r_out_val  <= r_val;
            r_out_last <= r_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_dest_index   = r_out_idx;
    assign o_value_out    = r_out_val;
    assign o_last_element = r_out_last;

    `ASSERT_NEVER(a_emit_overwrite, i_cmd.emit && r_out_valid && !i_out_ready, "emit over pending item")
    `ASSERT_CLK(a_cmd_onehot, $onehot0({i_cmd.load, i_cmd.step, i_cmd.emit}), "commands overlap")
    `ASSERT_CLK(a_step_in_rank, i_cmd.step |-> ({1'b0, r_d} < eff_rank), "step past rank")
    `ASSERT_CLK(a_wrap_zero, (i_cmd.load && n_last) |=> (r_pos[0] == '0 && r_pos[NUM_AXES-1] == '0), "odometer did not wrap")

endmodule

// ----- rtl/tensor_permute_address_gen.sv -----
// Streaming address generator for a tensor axis permutation. Elements of a tensor of up to four
// axes enter in source row-major order, one per input item; each leaves with its flat row-major
// index in the permuted tensor, and the final element of the tensor is flagged last, after which
// the position counter wraps to zero. Each item is accepted, takes a Horner step per destination
// axis in the shared multiply-add unit and is written to the output register once it is free,
// before the next item is accepted. The output register lets the next item be accepted while the
// previous result waits. Configuration must be written only while idle, which is not enforced.
module tensor_permute_address_gen #(
    parameter int MAX_RANK  = 4,
    parameter int ELEM_BITS = 32,
    parameter int AXIS_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tpag_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpag_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tpag_in_if.sink                         i_in,
    tpag_out_if.source                      o_out
);
    import tpag_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tpag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tpag_dp #(
        .MAX_RANK  (MAX_RANK),
        .ELEM_BITS (ELEM_BITS),
        .AXIS_BITS (AXIS_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_element_value (i_in.element_value),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_dest_index    (o_out.dest_index),
        .o_value_out     (o_out.value_out),
        .o_last_element  (o_out.last_element)
    );

endmodule
